// ===== rtl/pn_pkg.sv =====
package pn_pkg;

    // default sizes of the segment stack and the byte store
    localparam int MAX_SEGS_DEF    = 10;
    localparam int STORE_BYTES_DEF = 64;

    // capacity register
    localparam int             CAP_W     = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // character class decided by the front
    typedef enum logic [1:0] {
        K_NOP   = 2'd0,
        K_SLASH = 2'd1,
        K_DOT   = 2'd2,
        K_CHAR  = 2'd3
    } t_kind;

    // one command word handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
    } t_cmd;

endpackage

// ===== rtl/pn_if.sv =====
// input channel: one path character per word
interface pn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// output channel: one character of the normalized path per word
interface pn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       status;
    logic       out_last;

    modport source (output valid, output out_char, output status, output out_last,
                    input ready);
    modport sink   (input valid, input out_char, input status, input out_last,
                    output ready);
endinterface

// ===== rtl/pn_front.sv =====
module pn_front
    import pn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    pn_in_if.sink  i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic r_ended;
    logic n_ended;

    // take a word whenever the queue has room
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // classify the character; everything after a NUL is dropped
    always_comb begin
        o_cmd.ch   = i_in.ch;
        o_cmd.last = i_in.last;
        priority if (r_ended || i_in.ch == CH_NUL) begin
            o_cmd.kind = K_NOP;
        end else if (i_in.ch == CH_SLASH) begin
            o_cmd.kind = K_SLASH;
        end else if (i_in.ch == CH_DOT) begin
            o_cmd.kind = K_DOT;
        end else begin
            o_cmd.kind = K_CHAR;
        end
    end

    // end-of-string flag, cleared at the end of each path
    always_comb begin
        n_ended = r_ended;
        if (o_push) begin
            n_ended = i_in.last ? 1'b0 : (r_ended || i_in.ch == CH_NUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else begin
            r_ended <= n_ended;
        end
    end

endmodule

// ===== rtl/pn_cmdq.sv =====
module pn_cmdq
    import pn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(CMDQ_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(CMDQ_DEPTH - 1);

    t_cmd             r_q [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rd];

    // pointer and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_P) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_P) ? '0 : r_rd + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/pn_back.sv =====
module pn_back
    import pn_pkg::*;
#(
    parameter int MAX_SEGS    = MAX_SEGS_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CAP_W-1:0] i_out_cap,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    pn_out_if.source         o_out
);

    localparam int AW     = $clog2(STORE_BYTES);
    localparam int WP_W   = $clog2(STORE_BYTES + 1);
    localparam int IDX_W  = WP_W + 1;
    localparam int CNT_W  = $clog2(MAX_SEGS + 1);
    localparam int SIDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CW     = CAP_W + 1;

    localparam logic [WP_W-1:0]  SB_W    = WP_W'(STORE_BYTES);
    localparam logic [WP_W-1:0]  LEN_ONE = WP_W'(1);
    localparam logic [IDX_W-1:0] SB_I    = IDX_W'(STORE_BYTES);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGS);
    localparam logic [CW-1:0]    SB_C    = CW'(STORE_BYTES);

    typedef enum logic [3:0] {
        S_PARSE = 4'b0001,
        S_CLOSE = 4'b0010,
        S_FIN   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        D_EMPTY = 2'd0,
        D_ONE   = 2'd1,
        D_TWO   = 2'd2,
        D_NAME  = 2'd3
    } t_dot;

    typedef struct packed {
        logic [7:0] c;
        logic       s;
        logic       l;
    } t_res;

    // parse state
    t_state            r_state, n_state;
    logic [WP_W-1:0]   r_wpos, n_wpos;
    logic [WP_W-1:0]   r_clen, n_clen;
    t_dot              r_dot, n_dot;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_err, n_err;
    logic [WP_W-1:0]   r_len, n_len;
    logic [WP_W-1:0]   r_idx, n_idx;

    // byte store and segment stack
    logic [7:0]        r_store  [STORE_BYTES];
    logic [AW-1:0]     r_starts [MAX_SEGS];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              st_we;
    logic [SIDX_W-1:0] st_addr;
    logic [AW-1:0]     st_data;

    // read stage
    logic              iss, iss_mem, iss_status, iss_last;
    logic [7:0]        iss_char;
    logic [AW-1:0]     rd_addr;
    logic              r_st_vld, r_st_mem, r_st_status, r_st_last;
    logic [7:0]        r_st_char;
    logic [7:0]        r_rdata;

    // output buffer
    t_res              r_ob [2];
    logic              r_obw, r_obr;
    logic [1:0]        r_occ;
    logic              pop;
    logic [2:0]        slots;
    logic              can_iss;
    t_res              push_word;

    // helpers
    logic              do_take, do_close;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt_m1;
    logic [SIDX_W-1:0] top_idx;
    logic [WP_W-1:0]   fin_len;
    logic [CW-1:0]     cap_ext, cap_eff;
    logic              no_space;

    assign o_cmd_pop = (r_state == S_PARSE) && i_cmd_valid;

    assign idx      = IDX_W'(r_wpos) + IDX_W'(1) + IDX_W'(r_clen);
    assign cnt_m1   = r_cnt - CNT_W'(1);
    assign top_idx  = cnt_m1[SIDX_W-1:0];
    assign fin_len  = (r_cnt == '0) ? LEN_ONE : r_wpos;
    assign cap_ext  = CW'(i_out_cap);
    assign cap_eff  = (cap_ext > SB_C) ? SB_C : cap_ext;
    assign no_space = (CW'(fin_len) + CW'(1)) > cap_eff;

    // room for one more word: buffered + in flight - leaving stays below two
    assign pop     = o_out.valid && o_out.ready;
    assign slots   = 3'(r_occ) + 3'(r_st_vld);
    assign can_iss = (slots < 3'd2) || (slots == 3'd2 && pop);

    // sequencer and parse datapath
    always_comb begin
        n_state    = r_state;
        n_wpos     = r_wpos;
        n_clen     = r_clen;
        n_dot      = r_dot;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_len      = r_len;
        n_idx      = r_idx;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = CH_NUL;
        st_we      = 1'b0;
        st_addr    = '0;
        st_data    = '0;
        iss        = 1'b0;
        iss_mem    = 1'b0;
        iss_char   = CH_NUL;
        iss_status = 1'b0;
        iss_last   = 1'b0;
        rd_addr    = '0;
        do_take    = 1'b0;
        do_close   = 1'b0;

        unique case (r_state)
            S_PARSE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        K_SLASH:      do_close = 1'b1;
                        K_DOT, K_CHAR: do_take = 1'b1;
                        default:      ;
                    endcase
                    if (i_cmd.last) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                do_close = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (r_err || no_space || r_cnt == '0) begin
                    // single word: error or bare root
                    if (can_iss) begin
                        iss        = 1'b1;
                        iss_status = r_err || no_space;
                        iss_char   = (r_err || no_space) ? CH_NUL : CH_SLASH;
                        iss_last   = 1'b1;
                        n_wpos     = '0;
                        n_cnt      = '0;
                        n_err      = 1'b0;
                        n_state    = S_PARSE;
                    end
                end else begin
                    n_len   = r_wpos;
                    n_idx   = '0;
                    n_wpos  = '0;
                    n_cnt   = '0;
                    n_err   = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_iss) begin
                    iss      = 1'b1;
                    iss_mem  = 1'b1;
                    rd_addr  = r_idx[AW-1:0];
                    iss_last = (r_idx + LEN_ONE == r_len);
                    if (iss_last) begin
                        n_state = S_PARSE;
                    end else begin
                        n_idx = r_idx + LEN_ONE;
                    end
                end
            end
            default: n_state = S_PARSE;
        endcase

        // segment character: slash slot check, dot tracking, byte write
        if (do_take) begin
            if (r_clen == '0) begin
                if (r_wpos >= SB_W) begin
                    n_err = 1'b1;
                end
                n_dot = (i_cmd.kind == K_DOT) ? D_ONE : D_NAME;
            end else if (r_dot == D_ONE && i_cmd.kind == K_DOT) begin
                n_dot = D_TWO;
            end else begin
                n_dot = D_NAME;
            end
            if (idx < SB_I) begin
                wr_en   = 1'b1;
                wr_addr = idx[AW-1:0];
                wr_data = i_cmd.ch;
            end else begin
                n_err = 1'b1;
            end
            if (r_clen != SB_W) begin
                n_clen = r_clen + LEN_ONE;
            end
        end

        // segment end: pop on dot-dot, push a kept name with its leading slash
        if (do_close && r_clen != '0) begin
            if (r_dot == D_TWO) begin
                if (r_cnt != '0) begin
                    n_cnt  = cnt_m1;
                    n_wpos = WP_W'(r_starts[top_idx]);
                end
            end else if (r_dot == D_NAME) begin
                if (r_cnt >= MAX_CNT) begin
                    n_err = 1'b1;
                end else if (!r_err) begin
                    st_we   = 1'b1;
                    st_addr = r_cnt[SIDX_W-1:0];
                    st_data = r_wpos[AW-1:0];
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_wpos  = r_wpos + LEN_ONE + r_clen;
                    wr_en   = 1'b1;
                    wr_addr = r_wpos[AW-1:0];
                    wr_data = CH_SLASH;
                end
            end
            n_clen = '0;
            n_dot  = D_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_PARSE;
            r_wpos   <= '0;
            r_clen   <= '0;
            r_dot    <= D_EMPTY;
            r_cnt    <= '0;
            r_err    <= 1'b0;
            r_st_vld <= 1'b0;
            r_occ    <= '0;
            r_obw    <= 1'b0;
            r_obr    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wpos   <= n_wpos;
            r_clen   <= n_clen;
            r_dot    <= n_dot;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_st_vld <= iss;
            r_occ    <= r_occ + 2'(r_st_vld) - 2'(pop);
            if (r_st_vld) begin
                r_obw <= !r_obw;
            end
            if (pop) begin
                r_obr <= !r_obr;
            end
        end
    end

    // emission counters and read stage payload
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_st_mem    <= iss_mem;
        r_st_char   <= iss_char;
        r_st_status <= iss_status;
        r_st_last   <= iss_last;
    end

    // byte store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        r_rdata <= r_store[rd_addr];
    end

    // segment start stack
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_starts[st_addr] <= st_data;
        end
    end

    // two-word output buffer
    assign push_word.c = r_st_mem ? r_rdata : r_st_char;
    assign push_word.s = r_st_status;
    assign push_word.l = r_st_last;

    always_ff @(posedge i_clk) begin
        if (r_st_vld) begin
            r_ob[r_obw] <= push_word;
        end
    end

    assign o_out.valid    = (r_occ != '0);
    assign o_out.out_char = r_ob[r_obr].c;
    assign o_out.status   = r_ob[r_obr].s;
    assign o_out.out_last = r_ob[r_obr].l;

endmodule

// ===== rtl/path_normalizer.sv =====
// Path normalizer. Takes a path one character per word on i_in, with last set
// on the final word, and returns the canonical path one character per word on
// o_out, out_last on the final one; a path with too many segments, a store
// overflow or no room in out_capacity gives a single word with out_char 0 and
// status 1. Characters are taken at one per cycle while the command queue has
// room: each costs one write to the byte store in the back end, and a four-word
// command queue lets input run on while the back end is busy. After the word
// marked last the back end closes the segment and then checks the length
// before emission, and emission reads the store one character per cycle, while
// the output buffer has room, through its registered read port. Input backs up
// into the queue while a result is being emitted.
// i_cfg_we writes out_capacity and must only be used while no path is in
// flight.
module path_normalizer
    import pn_pkg::*;
#(
    parameter int MAX_SEGS    = MAX_SEGS_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pn_in_if.sink            i_in,
    pn_out_if.source         o_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    logic [CAP_W-1:0] r_out_cap;
    logic             q_push, q_full, q_valid, q_pop;
    t_cmd             q_cmd_in, q_cmd_out;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_out_cap <= i_cfg_wdata;
        end
    end

    pn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_cmd_in)
    );

    pn_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd_out),
        .i_pop   (q_pop)
    );

    pn_back #(
        .MAX_SEGS    (MAX_SEGS),
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_cap   (r_out_cap),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd_out),
        .o_cmd_pop   (q_pop),
        .o_out       (o_out)
    );

    // an error word is always alone: last, with a zero character
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> o_out.out_last && o_out.out_char == CH_NUL)
        else $error("error word not final or not zero");

    // reset empties the output buffer
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output word present after reset");

    // a command is only taken while one is queued
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid && !$isunknown(q_cmd_out.kind))
        else $error("back end popped an empty queue");

endmodule
